// ----- hdl/assert_macros.svh -----
// Assertion macros for the heap sorter checker.
// No dependencies; taken in by the checker with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define HS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("heap_sorter port check failed");

// condition in the next cycle
`define HS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("heap_sorter port check failed");

`endif

// ----- hdl/hsort_pkg.sv -----
// Shared constants of the heap sorter.
// No dependencies; used by heap_sorter, hsort_checker, sort_order_checker and heap_sorter_test.
`default_nettype none

package hsort_pkg;
    localparam int HS_DATA_W    = 32;
    localparam int HS_MAX_ITEMS = 64;
endpackage

`default_nettype wire

// ----- hdl/heap_sorter.sv -----
// Batch heap sorter: loads signed values, heap-sorts them, streams them out ascending.
// Depends on hsort_pkg; value store and sequencer live here.
//
// channel  | dir | handshake             | tdata            | tlast
// s_axis   | in  | tvalid/tready         | data_value[31:0] | batch_end
// m_axis   | out | tvalid/tready         | sorted_value     | last_result
//
// Loading accepts items back to back; s_axis_tready is high only while loading.
// Sorting works one sift level at a time over the single-port value store, reading the children,
// comparing and writing back the swap; the readout reads each item from the store, then registers it.
// One shared signed compare decides every sift step.
// i_rst_n is synchronous, active low; it empties the batch and drops a pending result.
// m_axis_tready low holds the output register and stalls the readout.
`default_nettype none

module heap_sorter #(
    parameter int MAX_ITEMS = hsort_pkg::HS_MAX_ITEMS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [hsort_pkg::HS_DATA_W-1:0] s_axis_tdata,  // [31:0] data_value
    input  wire                             s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [hsort_pkg::HS_DATA_W-1:0] m_axis_tdata,  // [31:0] sorted_value
    output logic                            m_axis_tlast
);

    localparam int DW = hsort_pkg::HS_DATA_W;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = AW + 2;

    typedef enum logic [3:0] {
        ST_LOAD, ST_RD_NODE, ST_CAP_NODE, ST_RD_LEFT, ST_RD_RIGHT, ST_CMP_RIGHT,
        ST_SWAP_A, ST_SWAP_B, ST_X_RD0, ST_X_RDJ, ST_X_WR0, ST_X_WRJ,
        ST_EM_RD, ST_EM_OUT
    } t_state;

    t_state          r_state;
    logic [DW-1:0]   r_mem [MAX_ITEMS];
    logic [DW-1:0]   r_rdata;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_heap_n;
    logic [CW-1:0]   r_k;
    logic            r_build;
    logic [AW-1:0]   r_node;
    logic [DW-1:0]   r_node_val;
    logic [AW-1:0]   r_best_idx;
    logic [DW-1:0]   r_best_val;
    logic [DW-1:0]   r_root_val;
    logic [AW-1:0]   r_idx;
    logic            r_out_valid;
    logic [DW-1:0]   r_out_data;
    logic            r_out_last;

    logic            mem_re;
    logic [AW-1:0]   mem_ra;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [DW-1:0]   mem_wd;
    logic [XW-1:0]   left_idx;
    logic [XW-1:0]   right_idx;
    logic            left_ok;
    logic            right_ok;
    logic [DW-1:0]   cmp_b;
    logic            c_gt;
    logic            s_hs;
    logic            room;
    logic [CW-1:0]   count_new;
    logic [CW-1:0]   half_new;
    logic            em_last;

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    assign s_hs      = s_axis_tvalid && s_axis_tready;
    assign room      = (r_fill < CW'(MAX_ITEMS));
    assign count_new = room ? CW'(r_fill + CW'(1)) : r_fill;
    assign half_new  = count_new >> 1;

    assign left_idx  = {1'b0, r_node, 1'b1};
    assign right_idx = XW'(left_idx + XW'(1));
    assign left_ok   = (left_idx < XW'(r_heap_n));
    assign right_ok  = (right_idx < XW'(r_heap_n));
    assign em_last   = (CW'(r_idx) == CW'(r_count - CW'(1)));

    // shared signed compare
    assign cmp_b = (r_state == ST_CMP_RIGHT) ? r_best_val : r_node_val;
    assign c_gt  = ($signed(r_rdata) > $signed(cmp_b));

    always_comb begin
        mem_re = 1'b0;
        mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = r_node_val;
        case (r_state)
            ST_LOAD: begin
                mem_we = s_hs && room;
                mem_wa = r_fill[AW-1:0];
                mem_wd = s_axis_tdata;
            end
            ST_RD_NODE: begin
                mem_re = 1'b1;
                mem_ra = r_node;
            end
            ST_RD_LEFT: begin
                mem_re = left_ok;
                mem_ra = left_idx[AW-1:0];
            end
            ST_RD_RIGHT: begin
                mem_re = right_ok;
                mem_ra = right_idx[AW-1:0];
            end
            ST_SWAP_A: begin
                mem_we = (r_best_idx != r_node);
                mem_wa = r_node;
                mem_wd = r_best_val;
            end
            ST_SWAP_B: begin
                mem_we = 1'b1;
                mem_wa = r_best_idx;
                mem_wd = r_node_val;
            end
            ST_X_RD0: begin
                mem_re = 1'b1;
            end
            ST_X_RDJ: begin
                mem_re = 1'b1;
                mem_ra = r_k[AW-1:0];
            end
            ST_X_WR0: begin
                mem_we = 1'b1;
                mem_wd = r_rdata;
            end
            ST_X_WRJ: begin
                mem_we = 1'b1;
                mem_wa = r_k[AW-1:0];
                mem_wd = r_root_val;
            end
            ST_EM_RD: begin
                mem_re = 1'b1;
                mem_ra = r_idx;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (s_hs) begin
                        r_fill <= count_new;
                        if (s_axis_tlast) begin
                            r_fill   <= '0;
                            r_count  <= count_new;
                            r_heap_n <= count_new;
                            r_k      <= half_new;
                            r_node   <= AW'(half_new - CW'(1));
                            r_build  <= 1'b1;
                            r_idx    <= '0;
                            r_state  <= (count_new < CW'(2)) ? ST_EM_RD : ST_RD_NODE;
                        end
                    end
                end
                ST_RD_NODE: begin
                    r_state <= ST_CAP_NODE;
                end
                ST_CAP_NODE: begin
                    r_node_val <= r_rdata;
                    r_state    <= ST_RD_LEFT;
                end
                ST_RD_LEFT: begin
                    r_state <= ST_RD_RIGHT;
                    if (!left_ok) begin
                        r_best_idx <= r_node;
                        r_state    <= ST_SWAP_A;
                    end
                end
                ST_RD_RIGHT: begin
                    if (c_gt) begin
                        r_best_idx <= left_idx[AW-1:0];
                        r_best_val <= r_rdata;
                    end else begin
                        r_best_idx <= r_node;
                        r_best_val <= r_node_val;
                    end
                    r_state <= right_ok ? ST_CMP_RIGHT : ST_SWAP_A;
                end
                ST_CMP_RIGHT: begin
                    if (c_gt) begin
                        r_best_idx <= right_idx[AW-1:0];
                        r_best_val <= r_rdata;
                    end
                    r_state <= ST_SWAP_A;
                end
                ST_SWAP_A: begin
                    if (r_best_idx != r_node) begin
                        r_state <= ST_SWAP_B;
                    end else if (r_build) begin
                        if (r_k > CW'(1)) begin
                            r_k     <= CW'(r_k - CW'(1));
                            r_node  <= AW'(r_k - CW'(2));
                            r_state <= ST_RD_NODE;
                        end else begin
                            r_build <= 1'b0;
                            r_k     <= CW'(r_count - CW'(1));
                            r_state <= ST_X_RD0;
                        end
                    end else if (r_k > CW'(1)) begin
                        r_k     <= CW'(r_k - CW'(1));
                        r_state <= ST_X_RD0;
                    end else begin
                        r_idx   <= '0;
                        r_state <= ST_EM_RD;
                    end
                end
                ST_SWAP_B: begin
                    r_node  <= r_best_idx;
                    r_state <= ST_RD_LEFT;
                end
                ST_X_RD0: begin
                    r_state <= ST_X_RDJ;
                end
                ST_X_RDJ: begin
                    r_root_val <= r_rdata;
                    r_state    <= ST_X_WR0;
                end
                ST_X_WR0: begin
                    r_node_val <= r_rdata;
                    r_state    <= ST_X_WRJ;
                end
                ST_X_WRJ: begin
                    r_node   <= '0;
                    r_heap_n <= r_k;
                    r_state  <= ST_RD_LEFT;
                end
                ST_EM_RD: begin
                    r_state <= ST_EM_OUT;
                end
                ST_EM_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_rdata;
                        r_out_last  <= em_last;
                        if (em_last) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_idx   <= AW'(r_idx + AW'(1));
                            r_state <= ST_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hsort_checker.sv -----
// Port-level checker for heap_sorter, bound into every heap_sorter instance.
// Depends on hsort_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hsort_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             s_axis_tlast,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [hsort_pkg::HS_DATA_W-1:0]  m_axis_tdata,
    input wire                             m_axis_tlast
);

    logic s_hs;
    logic m_hs;

    assign s_hs = s_axis_tvalid && s_axis_tready;
    assign m_hs = m_axis_tvalid && m_axis_tready;

    // stalled result holds
    `HS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // closing item stops loading
    `HS_ASSERT_NEXT(a_close_stops, i_clk, i_rst_n, s_hs && s_axis_tlast, !s_axis_tready)
    // loading continues until the closing item
    `HS_ASSERT_NEXT(a_load_keeps, i_clk, i_rst_n, s_hs && !s_axis_tlast, s_axis_tready)
    // a fresh result never appears during loading unless the batch just ended
    `HS_ASSERT_SAME(a_no_out_in_load, i_clk, i_rst_n, s_axis_tready && $past(s_axis_tready) && !$past(m_hs), $stable(m_axis_tvalid) || !m_axis_tvalid)

endmodule

bind heap_sorter hsort_checker u_hsort_checker (.*);

`default_nettype wire

// ----- sim/sort_order_checker.sv -----
// Output checker for heap_sorter: watches the input and output streams.
// Predicts the ascending order of each batch and compares every sorted item.
// Depends on hsort_pkg for the data width and the store capacity.
module sort_order_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    input  wire                             s_axis_tready,
    input  wire  [hsort_pkg::HS_DATA_W-1:0] s_axis_tdata,   // [31:0] data_value
    input  wire                             s_axis_tlast,   // batch_end
    input  wire                             m_axis_tvalid,
    input  wire                             m_axis_tready,
    input  wire  [hsort_pkg::HS_DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    input  wire                             m_axis_tlast,   // last_result
    output int                              o_fail_count,
    output int                              o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [hsort_pkg::HS_DATA_W-1:0] value;
        logic                                   last;
    } t_sorted_item;

    logic signed [hsort_pkg::HS_DATA_W-1:0] batch_values[$];
    t_sorted_item                           sorted_expect[$];
    int                                     fail_count = 0;
    int                                     pending_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_count = pending_count;

    always @(posedge i_clk) begin : watch_streams
        logic signed [hsort_pkg::HS_DATA_W-1:0] in_value;
        int                                     slot;
        t_sorted_item                           head;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_value = $signed(s_axis_tdata);
                // drop values that arrive with the store full
                if (batch_values.size() < hsort_pkg::HS_MAX_ITEMS) begin
                    slot = 0;
                    while (slot < batch_values.size() && batch_values[slot] <= in_value)
                        slot++;
                    batch_values.insert(slot, in_value);
                end
                if (s_axis_tlast) begin
                    foreach (batch_values[k])
                        sorted_expect.push_back('{batch_values[k],
                                                  k == batch_values.size() - 1});
                    batch_values.delete();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_expect.size() == 0) begin
                    $error("unexpected item: sorted_value %0d last_result %0b",
                           $signed(m_axis_tdata), m_axis_tlast);
                    fail_count++;
                end else begin
                    head = sorted_expect.pop_front();
                    if ($signed(m_axis_tdata) !== head.value) begin
                        $error("sorted_value: expected %0d, actual %0d",
                               head.value, $signed(m_axis_tdata));
                        fail_count++;
                    end
                    if (m_axis_tlast !== head.last) begin
                        $error("last_result: expected %0b, actual %0b",
                               head.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending_count <= sorted_expect.size();
    end
endmodule

// ----- sim/heap_sorter_test.sv -----
// Top of the heap_sorter testbench: clock, reset, batch stimulus and verdict.
// Depends on hsort_pkg, heap_sorter and sort_order_checker.
module heap_sorter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 50;
    localparam int SMALL_ITEMS  = 22;
    localparam logic [hsort_pkg::HS_DATA_W-1:0] MOST_POSITIVE = 32'h7fff_ffff;
    localparam logic [hsort_pkg::HS_DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [hsort_pkg::HS_DATA_W-1:0] s_axis_tdata  = '0;    // [31:0] data_value
    logic                            s_axis_tlast  = 1'b0;  // batch_end
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hsort_pkg::HS_DATA_W-1:0] m_axis_tdata;          // [31:0] sorted_value
    logic                            m_axis_tlast;          // last_result

    int fail_count;
    int pending_count;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int sent_count  = 0;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    heap_sorter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sort_order_checker order_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_batch(input logic [hsort_pkg::HS_DATA_W-1:0] values[$]);
        foreach (values[k]) begin
            while ($urandom_range(0, 99) < gap_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= values[k];
            s_axis_tlast  <= (k == values.size() - 1);
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            sent_count++;
        end
    endtask

    function automatic logic [hsort_pkg::HS_DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7) - 4;
            1:       return MOST_POSITIVE - $urandom_range(0, 2);
            2:       return MOST_NEGATIVE + $urandom_range(0, 2);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_batch(input int size);
        logic [hsort_pkg::HS_DATA_W-1:0] values[$];
        repeat (size) values.push_back(pick_value());
        send_batch(values);
    endtask

    initial begin
        logic [hsort_pkg::HS_DATA_W-1:0] values[$];
        int                              phase_start;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        values = '{MOST_POSITIVE};
        send_batch(values);
        values = '{MOST_NEGATIVE};
        send_batch(values);
        values = '{32'd0};
        send_batch(values);
        values = '{MOST_POSITIVE, MOST_NEGATIVE};
        send_batch(values);
        values = '{-32'sd1, 32'sd1, 32'd0, MOST_NEGATIVE, MOST_POSITIVE, -32'sd1};
        send_batch(values);
        values = '{32'd5, 32'd5, 32'd5, 32'd5};
        send_batch(values);
        values = '{32'sd40, 32'sd30, 32'sd20, -32'sd10, MOST_NEGATIVE + 32'd1};
        send_batch(values);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 56;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 56;
                end
                default: begin
                    gap_pct   = 30;
                    stall_pct = 30;
                end
            endcase
            if (phase == 1)
                send_random_batch(hsort_pkg::HS_MAX_ITEMS);
            if (phase == 3)
                send_random_batch(hsort_pkg::HS_MAX_ITEMS + $urandom_range(1, 4));
            phase_start = sent_count;
            while (sent_count - phase_start < SMALL_ITEMS)
                send_random_batch($urandom_range(1, 12));
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
